FILE: design/tgd_pkg.sv
// shared constants and types for the trilateration solver
package tgd_pkg;
    localparam int FracBits  = 16;
    localparam int CoordW    = 28;
    localparam int RangeW    = 27;
    localparam int GainW     = 16;
    localparam int EpochW    = 8;
    localparam int RegIdxW   = 3;
    localparam int DataW     = 28;
    localparam int ThreshInt = ((1 << FracBits) + 500) / 1000;
    localparam int Thresh    = (ThreshInt < 1) ? 1 : ThreshInt;

    localparam logic [RegIdxW-1:0] REG_AAX   = 3'd0;
    localparam logic [RegIdxW-1:0] REG_AAY   = 3'd1;
    localparam logic [RegIdxW-1:0] REG_ABX   = 3'd2;
    localparam logic [RegIdxW-1:0] REG_ABY   = 3'd3;
    localparam logic [RegIdxW-1:0] REG_ACX   = 3'd4;
    localparam logic [RegIdxW-1:0] REG_ACY   = 3'd5;
    localparam logic [RegIdxW-1:0] REG_GAIN  = 3'd6;
    localparam logic [RegIdxW-1:0] REG_EPOCH = 3'd7;

    localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
    localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

    typedef logic signed [CoordW-1:0] t_coord;

    // saturate a wide signed value to the coordinate range
    function automatic t_coord sat_coord(input logic signed [63:0] v);
        t_coord r;
        if (v > 64'(signed'(CoordMax))) r = CoordMax;
        else if (v < 64'(signed'(CoordMin))) r = CoordMin;
        else r = v[CoordW-1:0];
        return r;
    endfunction
endpackage

FILE: design/tgd_if.sv
// valid/ready channel interfaces
interface tgd_range_if;
    import tgd_pkg::*;
    logic              valid;
    logic              ready;
    logic [RangeW-1:0] range_a;
    logic [RangeW-1:0] range_b;
    logic [RangeW-1:0] range_c;
    modport source (output valid, range_a, range_b, range_c, input ready);
    modport sink   (input valid, range_a, range_b, range_c, output ready);
endinterface

interface tgd_pos_if;
    import tgd_pkg::*;
    logic   valid;
    logic   ready;
    t_coord pos_x;
    t_coord pos_y;
    logic   solve_failed;
    modport source (output valid, pos_x, pos_y, solve_failed, input ready);
    modport sink   (input valid, pos_x, pos_y, solve_failed, output ready);
endinterface

interface tgd_cfg_if;
    import tgd_pkg::*;
    logic               valid;
    logic               ready;
    logic [RegIdxW-1:0] index;
    logic [DataW-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/tgd_sqrt.sv
// iterative 64-bit floor square root, one result bit per cycle
module tgd_sqrt import tgd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_rem;
    logic [63:0] r_root;
    logic [63:0] r_bit;
    logic        r_busy;
    logic [63:0] w_trial;

    assign w_trial = r_root + r_bit;
    assign o_root  = r_root[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= i_rad;
                r_root <= '0;
                r_bit  <= 64'd1 << 62;
            end else if (r_busy) begin
                if (r_rem >= w_trial) begin
                    r_rem  <= r_rem - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: design/tgd_div.sv
// iterative signed divider, quotient truncated toward zero
module tgd_div import tgd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic [31:0]        i_den,
    output logic               o_done,
    output logic signed [63:0] o_quo
);
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;
    logic [63:0] w_qs;

    assign w_sh  = {r_rem[31:0], r_q[63]};
    assign w_qs  = r_q << 1;
    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_num[63];
                r_q    <= i_num[63] ? 64'(-i_num) : 64'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_q   <= w_qs | 64'd1;
                end else begin
                    r_rem <= w_sh;
                    r_q   <= w_qs;
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: design/trilateration_gradient_descent.sv
// trilateration solver top level: config regs, sequencer and shared units
//
//  channel   dir  payload
//  ------    ---  --------------------------------------
//  cfg       in   index, data (register write)
//  ranges    in   range_a, range_b, range_c
//  position  out  pos_x, pos_y, solve_failed
//
// a request runs the centroid state, epoch_count epochs, then the output state.
// an anchor term runs setup states, the square root, a division for x and one
// for y, each after a start state, and a step state; an anchor nearer than
// Thresh skips the divisions. each epoch ends in a move state. a zero range
// answers on the next cycle. ranges ready only when idle and the result
// register is empty. reset clears registers to their defaults.
module trilateration_gradient_descent import tgd_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    tgd_cfg_if.sink     cfg,
    tgd_range_if.sink   rng,
    tgd_pos_if.source   pos
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CENT  = 4'd1;
    localparam logic [3:0] S_DIFF  = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DIVX  = 4'd5;
    localparam logic [3:0] S_DIVY  = 4'd6;
    localparam logic [3:0] S_STEP  = 4'd7;
    localparam logic [3:0] S_MOVE  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_ERR   = 4'd10;
    localparam logic [3:0] S_WDX   = 4'd11;
    localparam logic [3:0] S_WDY   = 4'd12;

    t_coord            r_ax [3];
    t_coord            r_ay [3];
    logic [GainW-1:0]  r_gain;
    logic [EpochW-1:0] r_epochs;

    logic [3:0]        r_state;
    logic [RangeW-1:0] r_rng [3];
    t_coord            r_x, r_y, r_dx, r_dy, r_gx, r_gy, r_err;
    logic [1:0]        r_idx;
    logic [EpochW-1:0] r_ep;
    logic [63:0]       r_sqx, r_sqy;
    logic [27:0]       r_dist;
    logic signed [63:0] r_px, r_py;
    logic              r_ovalid;
    t_coord            r_ox, r_oy;
    logic              r_ofail;

    logic              w_sq_start, w_sq_done;
    logic [31:0]       w_root;
    logic              w_dv_start, w_dv_done;
    logic signed [63:0] w_num, w_quo;
    logic signed [63:0] w_sumx, w_sumy;
    logic [31:0]       w_absx, w_absy;
    logic [63:0]       w_recx, w_recy;
    t_coord            w_cx, w_cy;

    tgd_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
        .i_rad(r_sqx + r_sqy), .o_done(w_sq_done), .o_root(w_root)
    );

    tgd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dv_start),
        .i_num(w_num), .i_den({4'd0, r_dist}), .o_done(w_dv_done), .o_quo(w_quo)
    );

    assign w_sq_start = (r_state == S_SQ);
    assign w_dv_start = (r_state == S_WDX) || (r_state == S_WDY);
    assign w_num = 64'(2) * 64'(r_err) * ((r_state == S_WDX) ? 64'(r_dx) : 64'(r_dy));
    assign w_sumx = 64'(r_ax[0]) + 64'(r_ax[1]) + 64'(r_ax[2]);
    assign w_sumy = 64'(r_ay[0]) + 64'(r_ay[1]) + 64'(r_ay[2]);

    // centroid: magnitude times the reciprocal of 3, truncated toward zero
    assign w_absx = w_sumx[63] ? 32'(-w_sumx) : 32'(w_sumx);
    assign w_absy = w_sumy[63] ? 32'(-w_sumy) : 32'(w_sumy);
    assign w_recx = 64'(w_absx) * 64'h0000_0000_AAAA_AAAB;
    assign w_recy = 64'(w_absy) * 64'h0000_0000_AAAA_AAAB;
    assign w_cx = w_sumx[63] ? -t_coord'(w_recx >> 33) : t_coord'(w_recx >> 33);
    assign w_cy = w_sumy[63] ? -t_coord'(w_recy >> 33) : t_coord'(w_recy >> 33);

    assign cfg.ready = 1'b1;
    assign rng.ready = (r_state == S_IDLE) && !r_ovalid;
    assign pos.valid = r_ovalid;
    assign pos.pos_x = r_ox;
    assign pos.pos_y = r_oy;
    assign pos.solve_failed = r_ofail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_ax[i] <= '0;
                r_ay[i] <= '0;
            end
            r_gain   <= GainW'(3277);
            r_epochs <= EpochW'(100);
        end else if (cfg.valid) begin
            unique case (cfg.index)
                REG_AAX:   r_ax[0]  <= cfg.data;
                REG_AAY:   r_ay[0]  <= cfg.data;
                REG_ABX:   r_ax[1]  <= cfg.data;
                REG_ABY:   r_ay[1]  <= cfg.data;
                REG_ACX:   r_ax[2]  <= cfg.data;
                REG_ACY:   r_ay[2]  <= cfg.data;
                REG_GAIN:  r_gain   <= cfg.data[GainW-1:0];
                REG_EPOCH: r_epochs <= cfg.data[EpochW-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (pos.valid && pos.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (rng.valid && rng.ready) begin
                    r_rng[0] <= rng.range_a;
                    r_rng[1] <= rng.range_b;
                    r_rng[2] <= rng.range_c;
                    if (rng.range_a == '0 || rng.range_b == '0 || rng.range_c == '0) begin
                        r_ox <= -t_coord'(1 << FracBits);
                        r_oy <= -t_coord'(1 << FracBits);
                        r_ofail  <= 1'b1;
                        r_ovalid <= 1'b1;
                    end else begin
                        r_state <= S_CENT;
                    end
                end
                S_CENT: begin
                    r_x <= w_cx;
                    r_y <= w_cy;
                    r_ep <= '0;
                    r_idx <= '0;
                    r_gx <= '0;
                    r_gy <= '0;
                    r_state <= (r_epochs == '0) ? S_OUT : S_DIFF;
                end
                S_DIFF: begin
                    r_dx <= sat_coord(64'(r_x) - 64'(r_ax[r_idx]));
                    r_dy <= sat_coord(64'(r_y) - 64'(r_ay[r_idx]));
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_sqx <= 64'(r_dx) * 64'(r_dx);
                    r_sqy <= 64'(r_dy) * 64'(r_dy);
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_SQRT;
                S_SQRT: if (w_sq_done) begin
                    r_dist <= (w_root > 32'(CoordMax)) ? 28'(CoordMax) : w_root[27:0];
                    r_err <= sat_coord(64'(w_root > 32'(CoordMax) ? 32'(CoordMax) : w_root)
                                       - 64'(r_rng[r_idx]));
                    if (w_root < 32'(Thresh)) r_state <= S_STEP;
                    else r_state <= S_WDX;
                end
                S_WDX: r_state <= S_DIVX;
                S_DIVX: if (w_dv_done) begin
                    r_gx <= sat_coord(64'(r_gx) + 64'(sat_coord(w_quo)));
                    r_state <= S_WDY;
                end
                S_WDY: r_state <= S_DIVY;
                S_DIVY: if (w_dv_done) begin
                    r_gy <= sat_coord(64'(r_gy) + 64'(sat_coord(w_quo)));
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_idx == 2'd2) begin
                        r_px <= 64'(r_gx) * 64'(r_gain);
                        r_py <= 64'(r_gy) * 64'(r_gain);
                        r_state <= S_MOVE;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                        r_state <= S_DIFF;
                    end
                end
                S_MOVE: begin
                    // arithmetic shift gives the floor of the step
                    r_x <= sat_coord(64'(r_x) - (r_px >>> 16));
                    r_y <= sat_coord(64'(r_y) - (r_py >>> 16));
                    r_gx <= '0;
                    r_gy <= '0;
                    r_idx <= '0;
                    r_ep <= r_ep + 1'b1;
                    r_state <= (r_ep + 1'b1 == r_epochs) ? S_OUT : S_DIFF;
                end
                S_OUT: begin
                    r_ox <= r_x;
                    r_oy <= r_y;
                    r_ofail <= 1'b0;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !rng.ready) else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> pos.valid) else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pos.valid && pos.solve_failed) |-> (pos.pos_x == pos.pos_y))
        else $error("fail result mismatch");
endmodule
